[design/fpa_pkg.sv]
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  typedef logic [OP_W-1:0]          op_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam op_t OP_ADD      = 4'd0;
  localparam op_t OP_SUB      = 4'd1;
  localparam op_t OP_MUL      = 4'd2;
  localparam op_t OP_DIV      = 4'd3;
  localparam op_t OP_GT       = 4'd4;
  localparam op_t OP_LT       = 4'd5;
  localparam op_t OP_GE       = 4'd6;
  localparam op_t OP_LE       = 4'd7;
  localparam op_t OP_EQ       = 4'd8;
  localparam op_t OP_NE       = 4'd9;
  localparam op_t OP_MIN      = 4'd10;
  localparam op_t OP_MAX      = 4'd11;
  localparam op_t OP_INC      = 4'd12;
  localparam op_t OP_DEC      = 4'd13;
  localparam op_t OP_FROM_INT = 4'd14;
  localparam op_t OP_TO_INT   = 4'd15;

  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIV
  } cls_t;

  typedef struct packed {
    op_t   op;
    cls_t  cls;
    data_t a;
    data_t b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qpush_t;

endpackage

[design/fpa_req_if.sv]
`timescale 1ns / 1ps
interface fpa_req_if;
  logic                                valid;
  logic                                ready;
  logic [fpa_pkg::OP_W-1:0]            req_type;
  logic signed [fpa_pkg::DATA_W-1:0]   operand_a;
  logic signed [fpa_pkg::DATA_W-1:0]   operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                output ready);
endinterface

[design/fpa_rsp_if.sv]
`timescale 1ns / 1ps
interface fpa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpa_pkg::DATA_W-1:0]   result_value;
  logic                                divide_by_zero;

  modport source (output valid, output result_value, output divide_by_zero, input ready);
  modport sink (input valid, input result_value, input divide_by_zero, output ready);
endinterface

[design/fpa_front.sv]
`timescale 1ns / 1ps
module fpa_front (
  input  logic            clk,
  input  logic            rst_n,
  fpa_req_if.sink         in_ch,
  output fpa_pkg::qpush_t push,
  input  logic            push_ready
);
  import fpa_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  cls_t  cls;
  logic  in_fire;

  always_comb begin
    case (in_ch.req_type)
      OP_MUL:  cls = CLS_MUL;
      OP_DIV:  cls = CLS_DIV;
      default: cls = CLS_SIMPLE;
    endcase
  end

  assign in_ch.ready = !valid_r || push_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op  <= in_ch.req_type;
      item_r.cls <= cls;
      item_r.a   <= in_ch.operand_a;
      item_r.b   <= in_ch.operand_b;
    end
  end

  assign push.valid = valid_r;
  assign push.item  = item_r;

endmodule

[design/fpa_queue.sv]
`timescale 1ns / 1ps
module fpa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  fpa_pkg::qpush_t push,
  output logic            push_ready,
  output fpa_pkg::item_t  pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import fpa_pkg::*;

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic [Q_AW:0]   count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count_r != (Q_AW + 1)'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

[design/fpa_back.sv]
`timescale 1ns / 1ps
module fpa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fpa_pkg::item_t pop_item,
  input  logic           pop_valid,
  output logic           pop_ready,
  fpa_rsp_if.source      out_ch
);
  import fpa_pkg::*;

  // stage 0 sets up; stages 1..NUM_W each retire one quotient bit
  logic [NUM_W:0]    st_valid_r;
  op_t               st_op_r   [NUM_W+1];
  data_t             st_res_r  [NUM_W+1];
  logic              st_neg_r  [NUM_W+1];
  logic              st_dz_r   [NUM_W+1];
  logic [DATA_W-1:0] st_dvs_r  [NUM_W+1];
  logic [DATA_W-1:0] st_rem_r  [NUM_W+1];
  logic [NUM_W-1:0]  st_dq_r   [NUM_W+1];
  logic signed [PROD_W-1:0] prod_r;

  logic [DATA_W-1:0] rem_nxt [NUM_W+1];
  logic [NUM_W-1:0]  dq_nxt  [NUM_W+1];

  logic              out_valid_r;
  data_t             out_res_r;
  logic              out_dz_r;

  logic              adv;
  data_t             a;
  data_t             b;
  logic              lt;
  logic              gt;
  logic              eq;
  data_t             res_nxt;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]  num_abs;
  logic [DATA_W-1:0] dvs_abs;
  logic signed [PROD_W-1:0] prod_nxt;
  data_t             res1_nxt;
  logic [NUM_W-1:0]  quo_signed;
  data_t             fin_res;
  logic              fin_dz;

  assign adv       = !out_valid_r || out_ch.ready;
  assign pop_ready = adv;

  assign a = pop_item.a;
  assign b = pop_item.b;
  assign lt = a < b;
  assign gt = a > b;
  assign eq = a == b;

  always_comb begin
    case (pop_item.op)
      OP_ADD:      res_nxt = a + b;
      OP_SUB:      res_nxt = a - b;
      OP_GT:       res_nxt = DATA_W'(gt);
      OP_LT:       res_nxt = DATA_W'(lt);
      OP_GE:       res_nxt = DATA_W'(!lt);
      OP_LE:       res_nxt = DATA_W'(!gt);
      OP_EQ:       res_nxt = DATA_W'(eq);
      OP_NE:       res_nxt = DATA_W'(!eq);
      OP_MIN:      res_nxt = lt ? a : b;
      OP_MAX:      res_nxt = gt ? a : b;
      OP_INC:      res_nxt = a + 1'b1;
      OP_DEC:      res_nxt = a - 1'b1;
      OP_FROM_INT: res_nxt = a << FRAC_BITS;
      OP_TO_INT:   res_nxt = a >>> FRAC_BITS;
      default:     res_nxt = '0;
    endcase
  end

  assign num      = NUM_W'(a) <<< FRAC_BITS;
  assign num_abs  = a[DATA_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dvs_abs  = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign prod_nxt = a * b;

  assign res1_nxt = (st_op_r[0] == OP_MUL) ? prod_r[FRAC_BITS +: DATA_W] : st_res_r[0];

  // restoring divide, one bit per stage
  always_comb begin
    logic [DATA_W:0] t;
    logic            ge;
    rem_nxt[0] = '0;
    dq_nxt[0]  = '0;
    for (int k = 1; k <= NUM_W; k++) begin
      t  = {st_rem_r[k-1], st_dq_r[k-1][NUM_W-1]};
      ge = t >= {1'b0, st_dvs_r[k-1]};
      rem_nxt[k] = ge ? DATA_W'(t - {1'b0, st_dvs_r[k-1]}) : t[DATA_W-1:0];
      dq_nxt[k]  = {st_dq_r[k-1][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      st_valid_r  <= {st_valid_r[NUM_W-1:0], pop_valid};
      out_valid_r <= st_valid_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_op_r[0]  <= pop_item.op;
      st_res_r[0] <= res_nxt;
      st_neg_r[0] <= a[DATA_W-1] ^ b[DATA_W-1];
      st_dz_r[0]  <= (pop_item.cls == CLS_DIV) && (b == '0);
      st_dvs_r[0] <= dvs_abs;
      st_rem_r[0] <= '0;
      st_dq_r[0]  <= num_abs;
      prod_r      <= prod_nxt;
      for (int k = 1; k <= NUM_W; k++) begin
        st_op_r[k]  <= st_op_r[k-1];
        st_res_r[k] <= (k == 1) ? res1_nxt : st_res_r[k-1];
        st_neg_r[k] <= st_neg_r[k-1];
        st_dz_r[k]  <= st_dz_r[k-1];
        st_dvs_r[k] <= st_dvs_r[k-1];
        st_rem_r[k] <= rem_nxt[k];
        st_dq_r[k]  <= dq_nxt[k];
      end
      out_res_r <= fin_res;
      out_dz_r  <= fin_dz;
    end
  end

  assign quo_signed = st_neg_r[NUM_W] ? NUM_W'(-st_dq_r[NUM_W]) : st_dq_r[NUM_W];

  always_comb begin
    fin_dz  = 1'b0;
    fin_res = st_res_r[NUM_W];
    if (st_op_r[NUM_W] == OP_DIV) begin
      fin_dz  = st_dz_r[NUM_W];
      fin_res = st_dz_r[NUM_W] ? '0 : data_t'(quo_signed[DATA_W-1:0]);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_res_r;
  assign out_ch.divide_by_zero = out_dz_r;

endmodule

[design/fixed_point_alu.sv]
`timescale 1ns / 1ps
// Words are Q24.8. Throughput: one word per cycle unless the output stalls;
// the divider is a FRAC_BITS+32 stage restoring pipeline, one quotient bit per
// stage, and every operation rides the same stages.
// A stalled output holds the whole back end; a 4-entry queue decouples the front.
// Reset (rst_n low, synchronous) empties the front register, queue and pipeline.
module fixed_point_alu (
  input logic       clk,
  input logic       rst_n,
  fpa_req_if.sink   in_ch,
  fpa_rsp_if.source out_ch
);
  import fpa_pkg::*;

  qpush_t push;
  logic   push_ready;
  item_t  pop_item;
  logic   pop_valid;
  logic   pop_ready;

  fpa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  fpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  fpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
